/* hdl/ows_pkg.sv */
package ows_pkg;

    localparam int unsigned ROM_WIDTH    = 64;
    localparam int unsigned POS_WIDTH    = 7;
    localparam int unsigned FAM_WIDTH    = 4;
    localparam int unsigned IDX_WIDTH    = 6;
    localparam logic [POS_WIDTH-1:0] ROM_BITS_TOTAL = 7'd64;
    localparam logic [POS_WIDTH-1:0] FAMILY_LIMIT   = 7'd9;
    localparam logic [POS_WIDTH-1:0] FIRST_POS      = 7'd1;

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_START = 2'd1,
        FUNC_BITS  = 2'd2
    } ows_func_t;

    typedef enum logic [2:0] {
        ST_CONTINUE = 3'd0,
        ST_STARTED  = 3'd1,
        ST_FOUND    = 3'd2,
        ST_ENDED    = 3'd3,
        ST_CLEARED  = 3'd4,
        ST_IGNORED  = 3'd5
    } ows_status_t;

    typedef struct packed {
        logic [1:0] func;
        logic       no_presence;
        logic       id_bit;
        logic       complement_bit;
    } ows_in_t;

    typedef struct packed {
        logic [2:0]           status;
        logic                 direction_valid;
        logic                 direction;
        logic [ROM_WIDTH-1:0] rom_code;
        logic                 last_device;
        logic [FAM_WIDTH-1:0] family_discrepancy;
    } ows_out_t;

endpackage

/* hdl/ows_core.sv */
module ows_core
    import ows_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_fire,
    input  ows_in_t  in_word,
    output ows_out_t out_word
);

    logic [ROM_WIDTH-1:0] rom_bits_reg,         rom_bits_next;
    logic [POS_WIDTH-1:0] last_disc_reg,        last_disc_next;
    logic [FAM_WIDTH-1:0] family_disc_reg,      family_disc_next;
    logic                 last_device_reg,      last_device_next;
    logic [POS_WIDTH-1:0] bit_position_reg,     bit_position_next;
    logic [POS_WIDTH-1:0] zero_choice_pos_reg,  zero_choice_pos_next;
    logic                 searching_reg,        searching_next;

    logic [IDX_WIDTH-1:0] bit_idx;
    logic                 dir;
    logic [POS_WIDTH-1:0] pos_inc;
    ows_status_t          status;
    logic                 dir_valid;

    assign bit_idx = IDX_WIDTH'(bit_position_reg - FIRST_POS);
    assign pos_inc = bit_position_reg + FIRST_POS;

    always_comb begin
        rom_bits_next        = rom_bits_reg;
        last_disc_next       = last_disc_reg;
        family_disc_next     = family_disc_reg;
        last_device_next     = last_device_reg;
        bit_position_next    = bit_position_reg;
        zero_choice_pos_next = zero_choice_pos_reg;
        searching_next       = searching_reg;
        status               = ST_IGNORED;
        dir_valid            = 1'b0;
        dir                  = 1'b0;

        unique case (in_word.func)
            FUNC_CLEAR: begin
                rom_bits_next        = '0;
                last_disc_next       = '0;
                family_disc_next     = '0;
                last_device_next     = 1'b0;
                bit_position_next    = FIRST_POS;
                zero_choice_pos_next = '0;
                searching_next       = 1'b0;
                status               = ST_CLEARED;
            end
            FUNC_START: begin
                bit_position_next    = FIRST_POS;
                zero_choice_pos_next = '0;
                if (last_device_reg || in_word.no_presence) begin
                    searching_next   = 1'b0;
                    last_disc_next   = '0;
                    family_disc_next = '0;
                    last_device_next = 1'b0;
                    status           = ST_ENDED;
                end else begin
                    searching_next = 1'b1;
                    status         = ST_STARTED;
                end
            end
            FUNC_BITS: begin
                if (searching_reg) begin
                    if (in_word.id_bit && in_word.complement_bit) begin
                        searching_next   = 1'b0;
                        last_disc_next   = '0;
                        family_disc_next = '0;
                        last_device_next = 1'b0;
                        status           = ST_ENDED;
                    end else begin
                        if (in_word.id_bit != in_word.complement_bit) begin
                            dir = in_word.id_bit;
                        end else begin
                            if (bit_position_reg < last_disc_reg) begin
                                dir = rom_bits_reg[bit_idx];
                            end else begin
                                dir = (bit_position_reg == last_disc_reg);
                            end
                            if (!dir) begin
                                zero_choice_pos_next = bit_position_reg;
                                if (bit_position_reg < FAMILY_LIMIT) begin
                                    family_disc_next = bit_position_reg[FAM_WIDTH-1:0];
                                end
                            end
                        end
                        rom_bits_next[bit_idx] = dir;
                        dir_valid              = 1'b1;
                        bit_position_next      = pos_inc;
                        status                 = ST_CONTINUE;
                        if (pos_inc > ROM_BITS_TOTAL) begin
                            searching_next       = 1'b0;
                            last_disc_next       = zero_choice_pos_next;
                            last_device_next     = last_device_reg
                                                   | (zero_choice_pos_next == '0);
                            bit_position_next    = FIRST_POS;
                            zero_choice_pos_next = '0;
                            if (rom_bits_next[7:0] == 8'd0) begin
                                last_disc_next   = '0;
                                family_disc_next = '0;
                                last_device_next = 1'b0;
                                status           = ST_ENDED;
                            end else begin
                                status = ST_FOUND;
                            end
                        end
                    end
                end
            end
            default: begin
                status = ST_IGNORED;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_bits_reg        <= '0;
            last_disc_reg       <= '0;
            family_disc_reg     <= '0;
            last_device_reg     <= 1'b0;
            bit_position_reg    <= FIRST_POS;
            zero_choice_pos_reg <= '0;
            searching_reg       <= 1'b0;
        end else if (in_fire) begin
            rom_bits_reg        <= rom_bits_next;
            last_disc_reg       <= last_disc_next;
            family_disc_reg     <= family_disc_next;
            last_device_reg     <= last_device_next;
            bit_position_reg    <= bit_position_next;
            zero_choice_pos_reg <= zero_choice_pos_next;
            searching_reg       <= searching_next;
        end
    end

    always_comb begin
        out_word.status             = status;
        out_word.direction_valid    = dir_valid;
        out_word.direction          = dir;
        out_word.rom_code           = rom_bits_next;
        out_word.last_device        = last_device_next;
        out_word.family_discrepancy = family_disc_next;
    end

endmodule

/* hdl/ows_skid.sv */
module ows_skid
    import ows_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ows_out_t s_word,
    output logic     m_valid,
    input  logic     m_ready,
    output ows_out_t m_word
);

    logic     out_valid_reg,  out_valid_next;
    logic     skid_valid_reg, skid_valid_next;
    ows_out_t out_word_reg,   out_word_next;
    ows_out_t skid_word_reg,  skid_word_next;
    logic     s_fire;
    logic     out_free;

    assign s_ready  = !skid_valid_reg;
    assign s_fire   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_word_next   = out_word_reg;
        skid_word_next  = skid_word_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = s_fire;
                out_word_next  = s_word;
            end
        end else if (s_fire) begin
            skid_valid_next = 1'b1;
            skid_word_next  = s_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign m_valid = out_valid_reg;
    assign m_word  = out_word_reg;

endmodule

/* hdl/onewire_rom_search_engine.sv */
// Each result word is registered in the two-entry output stage once its input is accepted.
// Throughput: one word per cycle while the skid entry is empty; the decision logic and
// search state update in the accepting cycle, and s_ready is registered (low while full).
// Reset: aresetn is synchronous and active low; it clears the search state to idle
// with bit position one and empties the output stage.
module onewire_rom_search_engine
    import ows_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ows_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ows_out_t m_data
);

    logic     in_fire;
    ows_out_t result;

    assign in_fire = s_valid && s_ready;

    ows_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_word  (s_data),
        .out_word (result)
    );

    ows_skid u_skid (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (result),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_data)
    );

endmodule

/* hdl/ows_checker.sv */
module ows_checker
    import ows_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     m_valid,
    input logic     m_ready,
    input ows_out_t m_data
);

    // A stalled result word must hold.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_dir_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.direction_valid |-> !m_data.direction)
        else $error("direction set without direction_valid");

    a_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_CLEARED |->
            m_data.rom_code == '0 && !m_data.last_device
            && m_data.family_discrepancy == '0 && !m_data.direction_valid)
        else $error("clear left search state behind");

    a_family: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.family_discrepancy < FAM_WIDTH'(FAMILY_LIMIT))
        else $error("family discrepancy out of range");

    a_continue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_CONTINUE |-> m_data.direction_valid)
        else $error("continue without a direction bit");

endmodule

bind onewire_rom_search_engine ows_checker u_ows_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

/* tb/sv/tb_top.sv */
module tb_top;

    import ows_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int TARGET_WORDS   = 600;
    localparam int ENUM_SPAN      = 270;
    localparam int CALM_WORDS     = 100;
    localparam int HOLD_AT_WORD   = 150;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;

    localparam int DEV_RANDOM    = 0;
    localparam int DEV_ZERO_FAM  = 1;
    localparam int DEV_ALL_ONES  = 2;

    typedef struct packed {
        logic [63:0] rom;
        logic [6:0]  last_disc;
        logic [3:0]  fam_disc;
        logic        last_dev;
        logic [6:0]  bit_pos;
        logic [6:0]  zero_mark;
        logic        searching;
    } search_state_t;

    logic     aclk = 1'b0;
    logic     aresetn;
    logic     s_valid = 1'b0;
    logic     s_ready;
    ows_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    ows_out_t m_data;

    ows_in_t       pending_words[$];
    ows_out_t      expected_words[$];
    search_state_t plan_state;
    search_state_t track_state;
    int            total_words = TARGET_WORDS;
    int            accepted_in = 0;
    int            mismatches = 0;
    int            idle_cycles = 0;
    int            send_gap = 0;
    int            stall_left = 0;
    int            hold_left = 0;
    bit            hold_done = 1'b0;
    bit            word_taken = 1'b0;
    logic          calm;

    assign calm = (accepted_in + CALM_WORDS >= total_words);

    onewire_rom_search_engine dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic search_state_t idle_state();
        search_state_t st;
        st = '0;
        st.bit_pos = FIRST_POS;
        return st;
    endfunction

    function automatic ows_out_t search_step(inout search_state_t st, input ows_in_t w);
        ows_out_t    r;
        logic [6:0]  p;
        logic [5:0]  idx;
        logic        dir;
        r = '0;
        r.status = ST_IGNORED;
        dir = 1'b0;
        case (w.func)
            FUNC_CLEAR: begin
                st = idle_state();
                r.status = ST_CLEARED;
            end
            FUNC_START: begin
                st.searching = 1'b0;
                st.bit_pos = FIRST_POS;
                st.zero_mark = '0;
                if (st.last_dev || w.no_presence) begin
                    st.last_disc = '0;
                    st.last_dev = 1'b0;
                    st.fam_disc = '0;
                    r.status = ST_ENDED;
                end else begin
                    st.searching = 1'b1;
                    r.status = ST_STARTED;
                end
            end
            FUNC_BITS: begin
                if (st.searching && w.id_bit && w.complement_bit) begin
                    st.searching = 1'b0;
                    st.last_disc = '0;
                    st.last_dev = 1'b0;
                    st.fam_disc = '0;
                    r.status = ST_ENDED;
                end else if (st.searching) begin
                    p = st.bit_pos;
                    idx = 6'(p - 7'd1);
                    if (w.id_bit != w.complement_bit) begin
                        dir = w.id_bit;
                    end else begin
                        if (p < st.last_disc) begin
                            dir = st.rom[idx];
                        end else begin
                            dir = (p == st.last_disc);
                        end
                        if (!dir) begin
                            st.zero_mark = p;
                            if (p < FAMILY_LIMIT) begin
                                st.fam_disc = p[3:0];
                            end
                        end
                    end
                    st.rom[idx] = dir;
                    r.direction_valid = 1'b1;
                    st.bit_pos = p + 7'd1;
                    r.status = ST_CONTINUE;
                    if (st.bit_pos > ROM_BITS_TOTAL) begin
                        st.searching = 1'b0;
                        st.last_disc = st.zero_mark;
                        if (st.last_disc == '0) begin
                            st.last_dev = 1'b1;
                        end
                        if (st.rom[7:0] == 8'h00) begin
                            st.last_disc = '0;
                            st.last_dev = 1'b0;
                            st.fam_disc = '0;
                            r.status = ST_ENDED;
                        end else begin
                            r.status = ST_FOUND;
                        end
                        st.bit_pos = FIRST_POS;
                        st.zero_mark = '0;
                    end
                end
            end
            default: begin
            end
        endcase
        r.direction = dir;
        r.rom_code = st.rom;
        r.last_device = st.last_dev;
        r.family_discrepancy = st.fam_disc;
        return r;
    endfunction

    function automatic ows_out_t queue_word(logic [1:0] f, logic np, logic id, logic cmp);
        ows_in_t w;
        w.func = f;
        w.no_presence = np;
        w.id_bit = id;
        w.complement_bit = cmp;
        pending_words.push_back(w);
        return search_step(plan_state, w);
    endfunction

    task automatic queue_noise(input int count);
        ows_out_t r;
        int       pick;
        logic [1:0] f;
        repeat (count) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                f = FUNC_CLEAR;
            end else if (pick <= 3) begin
                f = FUNC_START;
            end else if (pick <= 8) begin
                f = FUNC_BITS;
            end else begin
                f = FUNC_UNUSED;
            end
            r = queue_word(f, $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_enumeration(input int n_dev, input int flavour);
        logic [63:0] codes[4];
        logic [3:0]  alive;
        logic        id;
        logic        cmp;
        ows_out_t    r;
        int          brk;
        int          kind;
        for (int k = 0; k < 4; k++) begin
            codes[k] = {$urandom, $urandom};
            kind = $urandom_range(0, 5);
            if (flavour == DEV_ZERO_FAM || (kind == 0)) begin
                codes[k][7:0] = 8'h00;
            end else if (flavour == DEV_ALL_ONES) begin
                codes[k] = '1;
            end else if (k > 0 && kind == 1) begin
                codes[k][7:0] = codes[0][7:0] ^ (8'h01 << $urandom_range(0, 7));
            end else if (k > 0 && kind == 2) begin
                codes[k] = codes[0] ^ (64'h1 << $urandom_range(8, 63));
            end
        end
        r = queue_word(FUNC_CLEAR, 1'b0, 1'b0, 1'b0);
        for (int pass = 0; pass <= n_dev; pass++) begin
            r = queue_word(FUNC_START, $urandom_range(0, 19) == 0, 1'b0, 1'b0);
            if (r.status != ST_STARTED) begin
                continue;
            end
            alive = '0;
            for (int k = 0; k < n_dev; k++) begin
                alive[k] = 1'b1;
            end
            brk = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : -1;
            for (int b = 0; b < 64; b++) begin
                if (b == brk) begin
                    case ($urandom_range(0, 3))
                        0: r = queue_word(FUNC_BITS, 1'b0, 1'b1, 1'b1);
                        1: r = queue_word(FUNC_START, 1'b0, 1'b0, 1'b0);
                        2: r = queue_word(FUNC_CLEAR, 1'b0, 1'b0, 1'b0);
                        default: r = queue_word(FUNC_UNUSED, 1'b1, 1'b1, 1'b1);
                    endcase
                    break;
                end
                id = 1'b1;
                cmp = 1'b1;
                for (int k = 0; k < n_dev; k++) begin
                    if (alive[k]) begin
                        id &= codes[k][b];
                        cmp &= ~codes[k][b];
                    end
                end
                r = queue_word(FUNC_BITS, 1'b0, id, cmp);
                for (int k = 0; k < n_dev; k++) begin
                    if (codes[k][b] != r.direction) begin
                        alive[k] = 1'b0;
                    end
                end
                if (r.status != ST_CONTINUE) begin
                    break;
                end
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [63:0] want_v,
                                 input logic [63:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(negedge aclk) begin
        if (aresetn && (!s_valid || word_taken)) begin
            if (send_gap > 0 && !calm) begin
                s_valid <= 1'b0;
                send_gap--;
            end else if (pending_words.size() != 0) begin
                s_valid <= 1'b1;
                s_data <= pending_words.pop_front();
                if (!calm && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(1, 8);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (!hold_done && accepted_in >= HOLD_AT_WORD) begin
                m_ready <= 1'b0;
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
            end else if (stall_left > 0 && !calm) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0) begin
                    stall_left = $urandom_range(1, 8);
                end
            end
        end
    end

    always @(posedge aclk) begin
        ows_out_t want;
        if (aresetn) begin
            word_taken = s_valid && s_ready;
            if (word_taken) begin
                expected_words.push_back(search_step(track_state, s_data));
                accepted_in++;
            end
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $error("result word with no expectation pending: 'h%0h", m_data);
                    mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    compare_field("status", 64'(want.status), 64'(m_data.status));
                    compare_field("direction_valid", 64'(want.direction_valid),
                                  64'(m_data.direction_valid));
                    compare_field("direction", 64'(want.direction),
                                  64'(m_data.direction));
                    compare_field("rom_code", want.rom_code, m_data.rom_code);
                    compare_field("last_device", 64'(want.last_device),
                                  64'(m_data.last_device));
                    compare_field("family_discrepancy", 64'(want.family_discrepancy),
                                  64'(m_data.family_discrepancy));
                end
            end
            if (word_taken || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        ows_out_t r;
        aresetn = 1'b0;
        plan_state = idle_state();
        track_state = idle_state();

        r = queue_word(FUNC_CLEAR, 1'b0, 1'b0, 1'b0);
        r = queue_word(FUNC_BITS, 1'b0, 1'b1, 1'b0);
        r = queue_word(FUNC_UNUSED, 1'b1, 1'b1, 1'b1);
        r = queue_word(FUNC_START, 1'b1, 1'b0, 1'b0);
        r = queue_word(FUNC_START, 1'b0, 1'b0, 1'b0);
        r = queue_word(FUNC_BITS, 1'b0, 1'b0, 1'b1);
        r = queue_word(FUNC_BITS, 1'b0, 1'b1, 1'b0);
        r = queue_word(FUNC_BITS, 1'b0, 1'b0, 1'b0);
        r = queue_word(FUNC_UNUSED, 1'b0, 1'b0, 1'b0);
        r = queue_word(FUNC_START, 1'b0, 1'b1, 1'b1);
        r = queue_word(FUNC_BITS, 1'b0, 1'b0, 1'b0);
        r = queue_word(FUNC_BITS, 1'b1, 1'b1, 1'b1);
        r = queue_word(FUNC_BITS, 1'b0, 1'b0, 1'b0);
        r = queue_word(FUNC_START, 1'b0, 1'b0, 1'b0);
        r = queue_word(FUNC_BITS, 1'b0, 1'b1, 1'b0);
        r = queue_word(FUNC_CLEAR, 1'b1, 1'b1, 1'b1);
        r = queue_word(FUNC_BITS, 1'b0, 1'b0, 1'b1);
        run_enumeration(1, DEV_ZERO_FAM);
        run_enumeration(1, DEV_ALL_ONES);
        while (pending_words.size() < TARGET_WORDS) begin
            if (pending_words.size() + ENUM_SPAN < TARGET_WORDS
                && $urandom_range(0, 9) < 7) begin
                run_enumeration($urandom_range(1, 3), DEV_RANDOM);
            end else begin
                queue_noise($urandom_range(3, 12));
            end
        end
        total_words = pending_words.size();

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (accepted_in < total_words) @(posedge aclk);
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* onewire_rom_search_engine.f */
hdl/ows_pkg.sv
hdl/ows_core.sv
hdl/ows_skid.sv
hdl/onewire_rom_search_engine.sv
hdl/ows_checker.sv
tb/sv/tb_top.sv
